### sv/hoff_pkg.sv
// ----------------------------------------------------------------------------
// hoff_pkg: heater off safety timeout shared types
// Request codes, input and result word layouts, register indexes.
// ----------------------------------------------------------------------------
package hoff_pkg;

  localparam int unsigned HeaterCount = 3;
  localparam int unsigned PinWidth    = 3;

  localparam logic [7:0] PinMask = 8'((1 << HeaterCount) - 1);

  localparam logic [31:0] TimeoutReset = 32'd1000;
  localparam logic [31:0] ElapsedMax   = 32'hFFFF_FFFF;
  localparam logic [15:0] TripsMax     = 16'hFFFF;

  typedef enum logic [1:0] {
    ReqTick   = 2'd0,
    ReqUpdate = 2'd1,
    ReqCheck  = 2'd2,
    ReqReset  = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    CfgTimeout  = 1'b0,
    CfgInverted = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    req_e                  req_type;
    logic [1:0]            level_req;
    logic [PinWidth-1:0]   pin_states;
  } in_t;

  typedef struct packed {
    logic        timer_on;
    logic        timeout_fired;
    logic        timeout_latched;
    logic        safe_status;
    logic        pins_off;
    logic [31:0] elapsed_cnt;
    logic [31:0] remain_cnt;
    logic [15:0] trip_count;
  } out_t;

endpackage

### sv/heater_off_safety_timeout.sv
// ----------------------------------------------------------------------------
// heater_off_safety_timeout: heater switch-off watchdog
// Result words are registered in a two-entry output buffer, a result register
// plus a skid register, which keeps the input open while one result is stalled.
// Throughput: one word per cycle while the skid register is empty.
// Reset: timer disarmed, trip flag and counters cleared, timeout 1000 ms,
// normal pin polarity; result buffer empty.
// ----------------------------------------------------------------------------
module heater_off_safety_timeout
  import hoff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_word_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_word_o,

  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] timeout_q;
  logic        inverted_q;

  logic        armed_q, armed_d;
  logic        tripped_q, tripped_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [15:0] trips_q, trips_d;

  logic        main_vld_q, main_vld_d;
  logic        skid_vld_q, skid_vld_d;
  out_t        main_q, main_d;
  out_t        skid_q, skid_d;

  logic        accept;
  logic        out_pop;
  logic        main_free;

  logic [7:0]  pins;
  logic        off;
  logic        fired;
  logic        expired_now;
  logic        below_timeout;
  out_t        result;

  assign in_stall_o  = skid_vld_q;
  assign accept      = in_valid_i & ~skid_vld_q;
  assign out_pop     = main_vld_q & ~out_stall_i;
  assign main_free   = ~main_vld_q | out_pop;
  assign out_valid_o = main_vld_q;
  assign out_word_o  = main_q;

  always_comb begin
    pins = {{(8 - PinWidth){1'b0}}, in_word_i.pin_states} & PinMask;
    off  = inverted_q ? (pins == PinMask) : (pins == 8'd0);

    armed_d     = armed_q;
    tripped_d   = tripped_q;
    elapsed_d   = elapsed_q;
    trips_d     = trips_q;
    fired       = 1'b0;
    expired_now = armed_q && (elapsed_q >= timeout_q);

    unique case (in_word_i.req_type)
      ReqTick: begin
        if (armed_q && elapsed_q != ElapsedMax) elapsed_d = elapsed_q + 32'd1;
      end
      ReqUpdate: begin
        if (in_word_i.level_req == 2'd0 && !armed_q) begin
          armed_d   = 1'b1;
          elapsed_d = '0;
          tripped_d = 1'b0;
        end
      end
      ReqCheck: begin
        if (!tripped_q && expired_now) begin
          if (off) begin
            armed_d = 1'b0;
          end else begin
            tripped_d = 1'b1;
            fired     = 1'b1;
            if (trips_q != TripsMax) trips_d = trips_q + 16'd1;
          end
        end
      end
      ReqReset: begin
        if (off) begin
          armed_d   = 1'b0;
          tripped_d = 1'b0;
        end
      end
      default: ;
    endcase

    below_timeout = elapsed_d < timeout_q;

    result.timer_on        = armed_d;
    result.timeout_fired   = fired;
    result.timeout_latched = tripped_d;
    result.safe_status     = ~(armed_d & ~below_timeout & ~off);
    result.pins_off        = off;
    result.elapsed_cnt     = armed_d ? elapsed_d : '0;
    result.remain_cnt      = (armed_d && below_timeout) ? (timeout_q - elapsed_d) : '0;
    result.trip_count      = trips_d;
  end

  always_comb begin
    main_vld_d = main_vld_q;
    main_d     = main_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;

    if (main_free) begin
      main_vld_d = skid_vld_q | accept;
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else if (accept) begin
        main_d = result;
      end
    end else if (accept) begin
      skid_vld_d = 1'b1;
      skid_d     = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TimeoutReset;
      inverted_q <= 1'b0;
      armed_q    <= 1'b0;
      tripped_q  <= 1'b0;
      elapsed_q  <= '0;
      trips_q    <= '0;
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTimeout:  timeout_q  <= cfg_data_i;
          CfgInverted: inverted_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        armed_q   <= armed_d;
        tripped_q <= tripped_d;
        elapsed_q <= elapsed_d;
        trips_q   <= trips_d;
      end
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule
